### hw/rtl/rvx_pkg.sv
// Shared constants and instruction encoders for the RV32IC executor.
package rvx_pkg;

    localparam int MEM_BYTES = 8192;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [2:0] ST_LOADED   = 3'd0;
    localparam logic [2:0] ST_EXECUTED = 3'd1;
    localparam logic [2:0] ST_SKIPPED  = 3'd2;
    localparam logic [2:0] ST_HALTED   = 3'd3;
    localparam logic [2:0] ST_FETCHERR = 3'd4;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_A7 = 5'd17;
    localparam logic [31:0] EXIT_SERVICE = 32'd10;

    function automatic logic [31:0] enc_i(input logic [31:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm[11:0], rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_s(input logic [31:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [31:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3);
        return {imm[12], imm[10:5], 5'd0, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [31:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

endpackage

### hw/rtl/rvx_expand.sv
// Compressed instruction expander: 16-bit form to its 32-bit equivalent.
module rvx_expand (
    input  logic [15:0] half,
    output logic        ok,
    output logic [31:0] word
);
    import rvx_pkg::*;

    logic [2:0]  f3;
    logic [4:0]  rd, rs2, rdp, rs2p;
    logic [31:0] imm6, imm;

    assign f3   = half[15:13];
    assign rd   = half[11:7];
    assign rs2  = half[6:2];
    assign rdp  = {2'b01, half[9:7]};
    assign rs2p = {2'b01, half[4:2]};
    assign imm6 = {{26{half[12]}}, half[12], half[6:2]};

    always_comb
    begin
        ok   = 1'b1;
        word = 32'd0;
        imm  = 32'd0;
        case (half[1:0])
            2'd0:
            begin
                if (f3 == 3'd0)
                begin
                    imm = {22'd0, half[10:7], half[12:11], half[5], half[6], 2'b00};
                    ok = (imm != 32'd0);
                    word = enc_i(imm, REG_SP, 3'd0, rs2p, OPC_OPIMM);
                end
                else
                begin
                    imm = {25'd0, half[5], half[12:10], half[6], 2'b00};
                    if (f3 == 3'd2)
                        word = enc_i(imm, rdp, 3'd2, rs2p, OPC_LOAD);
                    else if (f3 == 3'd6)
                        word = enc_s(imm, rs2p, rdp);
                    else
                        ok = 1'b0;
                end
            end
            2'd1:
            begin
                case (f3)
                    3'd0:
                    begin
                        if (rd == 5'd0 && imm6 == 32'd0)
                            word = {25'd0, OPC_OPIMM};
                        else if (rd == 5'd0 || imm6 == 32'd0)
                            ok = 1'b0;
                        else
                            word = enc_i(imm6, rd, 3'd0, rd, OPC_OPIMM);
                    end
                    3'd1, 3'd5:
                    begin
                        imm = {{21{half[12]}}, half[8], half[10:9], half[6], half[7],
                               half[2], half[11], half[5:3], 1'b0};
                        word = enc_j(imm, (f3 == 3'd1) ? REG_RA : 5'd0);
                    end
                    3'd2:
                    begin
                        ok = (rd != 5'd0);
                        word = enc_i(imm6, 5'd0, 3'd0, rd, OPC_OPIMM);
                    end
                    3'd3:
                    begin
                        if (rd == REG_SP)
                        begin
                            imm = {{23{half[12]}}, half[4:3], half[5], half[2], half[6], 4'd0};
                            ok = (imm != 32'd0);
                            word = enc_i(imm, REG_SP, 3'd0, REG_SP, OPC_OPIMM);
                        end
                        else
                        begin
                            ok = !(rd == 5'd0 || imm6 == 32'd0);
                            word = {imm6[19:0], rd, OPC_LUI};
                        end
                    end
                    3'd4:
                    begin
                        case (half[11:10])
                            2'd0, 2'd1:
                            begin
                                ok = !(half[12] || rs2 == 5'd0);
                                word = enc_i({21'd0, half[10], 5'd0, rs2}, rdp, 3'd5, rdp,
                                             OPC_OPIMM);
                            end
                            2'd2:
                                word = enc_i(imm6, rdp, 3'd7, rdp, OPC_OPIMM);
                            default:
                            begin
                                ok = !half[12];
                                case (half[6:5])
                                    2'd0:    word = enc_r(7'h20, rs2p, rdp, 3'd0, rdp);
                                    2'd1:    word = enc_r(7'h00, rs2p, rdp, 3'd4, rdp);
                                    2'd2:    word = enc_r(7'h00, rs2p, rdp, 3'd6, rdp);
                                    default: word = enc_r(7'h00, rs2p, rdp, 3'd7, rdp);
                                endcase
                            end
                        endcase
                    end
                    default:
                    begin
                        imm = {{24{half[12]}}, half[6:5], half[2], half[11:10], half[4:3], 1'b0};
                        word = enc_b(imm, rdp, (f3 == 3'd6) ? 3'd0 : 3'd1);
                    end
                endcase
            end
            2'd2:
            begin
                case (f3)
                    3'd0:
                    begin
                        ok = !(half[12] || rd == 5'd0 || rs2 == 5'd0);
                        word = enc_i({27'd0, rs2}, rd, 3'd1, rd, OPC_OPIMM);
                    end
                    3'd2:
                    begin
                        ok = (rd != 5'd0);
                        imm = {24'd0, half[3:2], half[12], half[6:4], 2'b00};
                        word = enc_i(imm, REG_SP, 3'd2, rd, OPC_LOAD);
                    end
                    3'd4:
                    begin
                        ok = (rd != 5'd0);
                        if (!half[12])
                            word = (rs2 == 5'd0) ? enc_i(32'd0, rd, 3'd0, 5'd0, OPC_JALR)
                                                 : enc_r(7'h00, rs2, 5'd0, 3'd0, rd);
                        else
                            word = (rs2 == 5'd0) ? enc_i(32'd0, rd, 3'd0, REG_RA, OPC_JALR)
                                                 : enc_r(7'h00, rs2, rd, 3'd0, rd);
                    end
                    3'd6:
                    begin
                        imm = {24'd0, half[8:7], half[12:9], 2'b00};
                        word = enc_s(imm, rs2, REG_SP);
                    end
                    default:
                        ok = 1'b0;
                endcase
            end
            default:
                ok = 1'b0;
        endcase
    end

endmodule

### hw/rtl/rv32ic_instruction_executor_top.sv
// RV32IC executor: byte memory, register file memory and a multi-cycle sequencer.
// Load request: the byte is written on acceptance; the result enters the output register
// from the finish state while the output is not stalled. Step request: each fetched byte
// (2 or 4) is read then captured, then decode, register reads, execute and retire follow;
// loads read and capture each data byte, stores write each byte. A new request is taken
// only once the result is in the output register. After reset all 8192 bytes are zeroed.
module rv32ic_instruction_executor_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [rvx_pkg::MEM_AW-1:0] load_address,
    input  logic [7:0]                load_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [12:0]               exec_pc,
    output logic [31:0]               inst_word,
    output logic                      is_compressed,
    output logic                      rd_written,
    output logic [4:0]                rd_index,
    output logic [31:0]               rd_value
);
    import rvx_pkg::*;

    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_FRD  = 13'b0000000000100,
        S_FWT  = 13'b0000000001000,
        S_DEC  = 13'b0000000010000,
        S_RA   = 13'b0000000100000,
        S_RB   = 13'b0000001000000,
        S_EXE  = 13'b0000010000000,
        S_MRD  = 13'b0000100000000,
        S_MWT  = 13'b0001000000000,
        S_MWR  = 13'b0010000000000,
        S_LWB  = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } state_t;

    state_t state_reg;

    logic [7:0]        mem [MEM_BYTES];
    logic [MEM_AW-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wd, mem_q;

    logic [31:0] rf [32];
    logic [31:0] rf_q, rf_rd, rf_wd;
    logic [31:0] rf_vld_reg;
    logic        rf_q_vld_reg, rf_we;
    logic [4:0]  rf_raddr, rf_waddr;

    logic [MEM_AW-1:0] clr_addr_reg, ea_reg;
    logic [12:0] pc_reg, epc_reg;
    logic        halted_reg, comp_reg;
    logic [2:0]  cnt_reg, nbytes_reg, st_reg;
    logic [31:0] w_reg, x_reg, a_reg, b_reg, ld_reg, rdv_reg;
    logic        rdw_reg;
    logic [4:0]  rdi_reg;

    logic        out_valid_reg, is_compressed_reg, rd_written_reg;
    logic [2:0]  status_reg;
    logic [12:0] exec_pc_reg;
    logic [31:0] inst_word_reg, rd_value_reg;
    logic [4:0]  rd_index_reg;

    logic        in_fire, out_load, exp_ok;
    logic [31:0] exp_word;
    logic [2:0]  size;
    logic [MEM_AW:0] fetch_end;

    // execute-stage decode
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] ii, is_imm, ib, ij, opb, alu, ea, lval, pcw;
    logic        bad, take, alt, slt, sltu;
    logic [12:0] seq_pc, br_pc;

    rvx_expand u_expand (
        .half (w_reg[15:0]),
        .ok   (exp_ok),
        .word (exp_word)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign size     = comp_reg ? 3'd2 : 3'd4;
    assign seq_pc   = pc_reg + 13'(size);

    // memory port
    always_comb
    begin
        mem_addr = '0;
        mem_we   = 1'b0;
        mem_wd   = 8'd0;
        case (state_reg)
            S_CLR:
            begin
                mem_addr = clr_addr_reg;
                mem_we   = 1'b1;
            end
            S_IDLE:
            begin
                mem_addr = load_address;
                mem_we   = in_fire && !kind;
                mem_wd   = load_data;
            end
            S_FRD:   mem_addr = MEM_AW'(pc_reg) + MEM_AW'(cnt_reg);
            S_MRD:   mem_addr = ea_reg + MEM_AW'(cnt_reg);
            S_MWR:
            begin
                mem_addr = ea_reg + MEM_AW'(cnt_reg);
                mem_we   = 1'b1;
                mem_wd   = 8'(b_reg >> {cnt_reg[1:0], 3'b000});
            end
            default: mem_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        mem_q <= mem[mem_addr];
    end

    // register file port; entries never written read as zero
    assign rf_raddr = (state_reg == S_RB) ? ((x_reg[6:0] == OPC_SYSTEM) ? REG_A7 : x_reg[24:20])
                                          : x_reg[19:15];
    assign rf_rd    = rf_q_vld_reg ? rf_q : 32'd0;

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_waddr] <= rf_wd;
        rf_q <= rf[rf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg   <= '0;
            rf_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_vld_reg[rf_waddr] <= 1'b1;
            rf_q_vld_reg <= rf_vld_reg[rf_raddr];
        end
    end

    // execute decode
    assign op = x_reg[6:0];
    assign f3 = x_reg[14:12];
    assign f7 = x_reg[31:25];
    assign rd = x_reg[11:7];
    assign ii = {{20{x_reg[31]}}, x_reg[31:20]};
    assign is_imm = {{20{x_reg[31]}}, x_reg[31:25], x_reg[11:7]};
    assign ib = {{19{x_reg[31]}}, x_reg[31], x_reg[7], x_reg[30:25], x_reg[11:8], 1'b0};
    assign ij = {{11{x_reg[31]}}, x_reg[31], x_reg[19:12], x_reg[20], x_reg[30:21], 1'b0};
    assign slt  = ($signed(a_reg) < $signed(opb));
    assign sltu = (a_reg < opb);

    always_comb
    begin
        bad  = 1'b0;
        take = 1'b0;
        opb  = rf_rd;
        alt  = (f7 == 7'h20);
        if (op == OPC_OPIMM)
        begin
            if (f3 == 3'd1 || f3 == 3'd5)
            begin
                opb = {27'd0, x_reg[24:20]};
                bad = (f7 != 7'h00) && !(f3 == 3'd5 && f7 == 7'h20);
            end
            else
            begin
                opb = ii;
                alt = 1'b0;
            end
        end
        else if (op == OPC_OP)
            bad = (f7 != 7'h00) && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5));
        case (f3)
            3'd0:    alu = alt ? a_reg - opb : a_reg + opb;
            3'd1:    alu = a_reg << opb[4:0];
            3'd2:    alu = {31'd0, slt};
            3'd3:    alu = {31'd0, sltu};
            3'd4:    alu = a_reg ^ opb;
            3'd5:    alu = alt ? 32'($signed(a_reg) >>> opb[4:0]) : a_reg >> opb[4:0];
            3'd6:    alu = a_reg | opb;
            default: alu = a_reg & opb;
        endcase
        case (f3)
            3'd0:    take = (a_reg == rf_rd);
            3'd1:    take = (a_reg != rf_rd);
            3'd4:    take = slt;
            3'd5:    take = !slt;
            3'd6:    take = sltu;
            3'd7:    take = !sltu;
            default: take = 1'b0;
        endcase
    end

    assign ea    = a_reg + ((op == OPC_STORE) ? is_imm : ii);
    assign br_pc = take ? pc_reg + ib[12:0] : seq_pc;
    assign pcw   = {19'd0, pc_reg};

    always_comb
    begin
        case (f3)
            3'd0:    lval = {{24{ld_reg[7]}}, ld_reg[7:0]};
            3'd1:    lval = {{16{ld_reg[15]}}, ld_reg[15:0]};
            3'd4:    lval = {24'd0, ld_reg[7:0]};
            3'd5:    lval = {16'd0, ld_reg[15:0]};
            default: lval = ld_reg;
        endcase
    end

    // register writes happen at execute for ALU, jump, LUI and AUIPC forms and at load retire
    // link value is not wrapped: an instruction ending at the top of memory links 8192
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = rd;
        rf_wd    = alu;
        if (state_reg == S_LWB)
        begin
            rf_we = (rd != 5'd0);
            rf_wd = lval;
        end
        else if (state_reg == S_EXE)
        begin
            case (op)
                OPC_OP, OPC_OPIMM: rf_we = !bad && (rd != 5'd0);
                OPC_JAL:           begin rf_we = (rd != 5'd0); rf_wd = pcw + 32'(size); end
                OPC_JALR:          begin rf_we = (f3 == 3'd0) && (rd != 5'd0);
                                         rf_wd = pcw + 32'(size); end
                OPC_LUI:           begin rf_we = (rd != 5'd0); rf_wd = {x_reg[31:12], 12'd0}; end
                OPC_AUIPC:         begin rf_we = (rd != 5'd0);
                                         rf_wd = pcw + {x_reg[31:12], 12'd0}; end
                default:           rf_we = 1'b0;
            endcase
        end
    end

    assign fetch_end = (MEM_AW+1)'(pc_reg) + (MEM_AW+1)'(size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            pc_reg        <= 13'd0;
            halted_reg    <= 1'b0;
            cnt_reg       <= 3'd0;
            nbytes_reg    <= 3'd0;
            st_reg        <= ST_LOADED;
            comp_reg      <= 1'b0;
            epc_reg       <= 13'd0;
            w_reg         <= 32'd0;
            x_reg         <= 32'd0;
            a_reg         <= 32'd0;
            b_reg         <= 32'd0;
            ld_reg        <= 32'd0;
            ea_reg        <= '0;
            rdw_reg       <= 1'b0;
            rdi_reg       <= 5'd0;
            rdv_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == MEM_AW'(MEM_BYTES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        w_reg    <= 32'd0;
                        comp_reg <= 1'b0;
                        rdw_reg  <= 1'b0;
                        rdi_reg  <= 5'd0;
                        rdv_reg  <= 32'd0;
                        cnt_reg  <= 3'd0;
                        if (!kind)
                        begin
                            st_reg    <= ST_LOADED;
                            epc_reg   <= 13'd0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            epc_reg <= pc_reg;
                            if (halted_reg)
                            begin
                                st_reg    <= ST_HALTED;
                                state_reg <= S_FIN;
                            end
                            else
                                state_reg <= S_FRD;
                        end
                    end
                end
                S_FRD:
                    state_reg <= S_FWT;
                S_FWT:
                begin
                    w_reg[8*cnt_reg[1:0] +: 8] <= mem_q;
                    if (cnt_reg == 3'd0)
                        comp_reg <= (mem_q[1:0] != 2'b11);
                    cnt_reg   <= cnt_reg + 3'd1;
                    state_reg <= S_FRD;
                    if (cnt_reg == 3'd1 && fetch_end > (MEM_AW+1)'(MEM_BYTES))
                    begin
                        // instruction runs past the end of memory
                        w_reg     <= 32'd0;
                        comp_reg  <= 1'b0;
                        st_reg    <= ST_FETCHERR;
                        state_reg <= S_FIN;
                    end
                    else if (cnt_reg != 3'd0 && cnt_reg + 3'd1 == size)
                        state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    x_reg <= comp_reg ? exp_word : w_reg;
                    if (comp_reg && !exp_ok)
                    begin
                        pc_reg    <= seq_pc;
                        st_reg    <= ST_SKIPPED;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_RA;
                end
                S_RA:
                    state_reg <= S_RB;
                S_RB:
                begin
                    a_reg     <= rf_rd;
                    state_reg <= S_EXE;
                end
                S_EXE:
                begin
                    b_reg     <= rf_rd;
                    ea_reg    <= ea[MEM_AW-1:0];
                    ld_reg    <= 32'd0;
                    cnt_reg   <= 3'd0;
                    pc_reg    <= seq_pc;
                    st_reg    <= ST_EXECUTED;
                    state_reg <= S_FIN;
                    rdi_reg   <= rd;
                    rdv_reg   <= rf_wd;
                    rdw_reg   <= rf_we;
                    case (op)
                        OPC_OP, OPC_OPIMM:
                            if (bad)
                                st_reg <= ST_SKIPPED;
                        OPC_LOAD:
                        begin
                            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                                st_reg <= ST_SKIPPED;
                            else
                            begin
                                nbytes_reg <= (f3[1:0] == 2'd0) ? 3'd1
                                            : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                                state_reg  <= S_MRD;
                            end
                        end
                        OPC_STORE:
                        begin
                            if (f3 > 3'd2)
                                st_reg <= ST_SKIPPED;
                            else
                            begin
                                nbytes_reg <= (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
                                state_reg  <= S_MWR;
                            end
                        end
                        OPC_BRANCH:
                        begin
                            if (f3 == 3'd2 || f3 == 3'd3)
                                st_reg <= ST_SKIPPED;
                            else
                                pc_reg <= br_pc;
                        end
                        OPC_JALR:
                        begin
                            if (f3 != 3'd0)
                                st_reg <= ST_SKIPPED;
                            else
                                pc_reg <= (a_reg[12:0] + ii[12:0]) & 13'h1FFE;
                        end
                        OPC_JAL:
                            pc_reg <= pc_reg + ij[12:0];
                        OPC_LUI, OPC_AUIPC:
                            st_reg <= ST_EXECUTED;
                        OPC_SYSTEM:
                        begin
                            if (f3 == 3'd0 && x_reg[31:20] == 12'd0 && rf_rd == EXIT_SERVICE)
                            begin
                                halted_reg <= 1'b1;
                                st_reg     <= ST_HALTED;
                            end
                            else
                                st_reg <= ST_SKIPPED;
                        end
                        default:
                            st_reg <= ST_SKIPPED;
                    endcase
                end
                S_MRD:
                    state_reg <= S_MWT;
                S_MWT:
                begin
                    ld_reg[8*cnt_reg[1:0] +: 8] <= mem_q;
                    cnt_reg   <= cnt_reg + 3'd1;
                    state_reg <= (cnt_reg + 3'd1 == nbytes_reg) ? S_LWB : S_MRD;
                end
                S_MWR:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg + 3'd1 == nbytes_reg)
                        state_reg <= S_FIN;
                end
                S_LWB:
                begin
                    rdw_reg   <= rf_we;
                    rdv_reg   <= rf_we ? lval : 32'd0;
                    rdi_reg   <= rf_we ? rd : 5'd0;
                    state_reg <= S_FIN;
                end
                S_FIN:
                    if (out_load)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase

            // destination fields read as zero when nothing was written
            if (state_reg == S_EXE && !rf_we)
            begin
                rdi_reg <= 5'd0;
                rdv_reg <= 32'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg        <= st_reg;
            exec_pc_reg       <= epc_reg;
            inst_word_reg     <= w_reg;
            is_compressed_reg <= comp_reg;
            rd_written_reg    <= rdw_reg;
            rd_index_reg      <= rdi_reg;
            rd_value_reg      <= rdv_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign exec_pc       = exec_pc_reg;
    assign inst_word     = inst_word_reg;
    assign is_compressed = is_compressed_reg;
    assign rd_written    = rd_written_reg;
    assign rd_index      = rd_index_reg;
    assign rd_value      = rd_value_reg;

endmodule

### hw/rtl/rvx_checker.sv
// Port-level checker for the RV32IC executor, bound to the top level.
module rvx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [12:0] exec_pc,
    input logic [31:0] inst_word,
    input logic        is_compressed,
    input logic        rd_written,
    input logic [4:0]  rd_index,
    input logic [31:0] rd_value
);
    import rvx_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_LOADED |-> exec_pc == 13'd0 && !rd_written
            && inst_word == 32'd0)
        else $error("load request result not clean");

    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rd_written |-> rd_index != 5'd0 && status == ST_EXECUTED)
        else $error("bad register write report");

    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rd_written |-> rd_index == 5'd0 && rd_value == 32'd0)
        else $error("destination fields set without a write");

    a_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_compressed |-> inst_word[31:16] == 16'd0 && inst_word[1:0] != 2'b11)
        else $error("compressed word malformed");

endmodule

bind rv32ic_instruction_executor_top rvx_checker u_rvx_checker (.*);
